[rtl/dtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, codes and constants of the dual timer tick unit.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // request operations
  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IEN0    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IEN1    = 2'd3;

  // bit positions in the control and mode registers
  localparam int unsigned RUN0_BIT  = 2;
  localparam int unsigned RUN1_BIT  = 6;
  localparam int unsigned MODE0_LSB = 0;
  localparam int unsigned MODE1_LSB = 4;

  // timer modes, three bits each; other codes leave the timer idle
  localparam logic [2:0] MODE_WIDE   = 3'd1;
  localparam logic [2:0] MODE_RELOAD = 3'd2;
  localparam logic [2:0] MODE_SPLIT  = 3'd3;

  // byte select codes: bit 1 picks the timer, bit 0 the high byte
  localparam int unsigned SEL_TIMER_BIT = 1;
  localparam int unsigned SEL_HIGH_BIT  = 0;

  typedef struct packed {
    logic       run0;
    logic       run1;
    logic [2:0] mode0;
    logic [2:0] mode1;
    logic       ien0;
    logic       ien1;
  } tmr_cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] ticks;
    logic [1:0] byte_select;
    logic [7:0] byte_value;
  } tmr_req_t;

  typedef struct packed {
    logic [15:0] zero_count;
    logic [15:0] one_count;
    logic        zero_pending;
    logic        one_pending;
  } tmr_view_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_status_t;

endpackage

[rtl/dtt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_if
// Request and result channels of the dual timer tick unit.
// ----------------------------------------------------------------------------
interface dtt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] ticks;
  logic [1:0] byte_select;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output ticks, output byte_select,
                  output byte_value, input ready);
  modport sink   (input valid, input operation, input ticks, input byte_select,
                  input byte_value, output ready);
endinterface

interface dtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] zero_low;
  logic [7:0] zero_high;
  logic [7:0] one_low;
  logic [7:0] one_high;
  logic       zero_pending;
  logic       one_pending;

  modport source (output valid, output zero_low, output zero_high, output one_low,
                  output one_high, output zero_pending, output one_pending,
                  input ready);
  modport sink   (input valid, input zero_low, input zero_high, input one_low,
                  input one_high, input zero_pending, input one_pending,
                  output ready);
endinterface

[rtl/dtt_tick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_tick
// One tick of one timer: byte incrementers, wrap detect and mode select.
// ----------------------------------------------------------------------------
module dtt_tick (
  input  logic        run,
  input  logic [2:0]  mode,
  input  logic [15:0] cnt,
  output logic [15:0] cnt_nxt,
  output logic        ovf
);
  import dtt_pkg::*;

  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] lo_inc;
  logic [7:0] hi_inc;
  logic       lo_wrap;
  logic       hi_wrap;

  assign lo      = cnt[7:0];
  assign hi      = cnt[15:8];
  assign lo_inc  = lo + 8'd1;
  assign hi_inc  = hi + 8'd1;
  assign lo_wrap = (lo == 8'hff);
  assign hi_wrap = (hi == 8'hff);

  always_comb begin
    cnt_nxt = cnt;
    ovf     = 1'b0;
    if (run) begin
      case (mode)
        MODE_WIDE: begin
          cnt_nxt = {(lo_wrap ? hi_inc : hi), lo_inc};
          ovf     = lo_wrap && hi_wrap;
        end
        MODE_RELOAD: begin
          // low byte reloads from the high byte on wrap
          cnt_nxt = {hi, (lo_wrap ? hi : lo_inc)};
          ovf     = lo_wrap;
        end
        MODE_SPLIT: begin
          cnt_nxt = {hi_inc, lo_inc};
          ovf     = lo_wrap || hi_wrap;
        end
        default: begin
          cnt_nxt = cnt;
          ovf     = 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/dtt_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_seq
// Timer state and the sequencer that steps both timers through one shared
// tick unit, timer zero then timer one, once per tick.
// ----------------------------------------------------------------------------
module dtt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  dtt_pkg::tmr_cfg_t   cfg,
  input  logic                start,
  input  dtt_pkg::tmr_req_t   req,
  input  logic                take,
  output dtt_pkg::seq_status_t status,
  output dtt_pkg::tmr_view_t  view
);
  import dtt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_T0   = 2'd1;
  localparam logic [1:0] ST_T1   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  ticks_left_r, ticks_left_nxt;
  logic [15:0] zero_r, zero_nxt;
  logic [15:0] one_r, one_nxt;
  logic [1:0]  pend_r, pend_nxt;

  logic        unit_run;
  logic [2:0]  unit_mode;
  logic [15:0] unit_cnt;
  logic [15:0] unit_cnt_nxt;
  logic        unit_ovf;
  logic        on_one;

  // shared unit sees timer one only in its own phase
  assign on_one    = (state_r == ST_T1);
  assign unit_run  = on_one ? cfg.run1 : cfg.run0;
  assign unit_mode = on_one ? cfg.mode1 : cfg.mode0;
  assign unit_cnt  = on_one ? one_r : zero_r;

  dtt_tick u_tick (
    .run     (unit_run),
    .mode    (unit_mode),
    .cnt     (unit_cnt),
    .cnt_nxt (unit_cnt_nxt),
    .ovf     (unit_ovf)
  );

  always_comb begin
    state_nxt      = state_r;
    ticks_left_nxt = ticks_left_r;
    zero_nxt       = zero_r;
    one_nxt        = one_r;
    pend_nxt       = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DONE;
          case (req.operation)
            OP_ADVANCE: begin
              if (req.ticks != 8'd0) begin
                ticks_left_nxt = req.ticks;
                state_nxt      = ST_T0;
              end
            end
            OP_WRITE: begin
              if (!req.byte_select[SEL_TIMER_BIT]) begin
                if (req.byte_select[SEL_HIGH_BIT]) zero_nxt[15:8] = req.byte_value;
                else                               zero_nxt[7:0]  = req.byte_value;
              end else begin
                if (req.byte_select[SEL_HIGH_BIT]) one_nxt[15:8] = req.byte_value;
                else                               one_nxt[7:0]  = req.byte_value;
              end
            end
            OP_CLEAR: begin
              pend_nxt = 2'b00;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_T0: begin
        zero_nxt = unit_cnt_nxt;
        if (unit_ovf && cfg.ien0) pend_nxt[0] = 1'b1;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        one_nxt = unit_cnt_nxt;
        if (unit_ovf && cfg.ien1) pend_nxt[1] = 1'b1;
        ticks_left_nxt = ticks_left_r - 8'd1;
        state_nxt      = (ticks_left_r == 8'd1) ? ST_DONE : ST_T0;
      end
      ST_DONE: begin
        if (take) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ticks_left_r <= 8'd0;
      zero_r       <= 16'd0;
      one_r        <= 16'd0;
      pend_r       <= 2'b00;
    end else begin
      state_r      <= state_nxt;
      ticks_left_r <= ticks_left_nxt;
      zero_r       <= zero_nxt;
      one_r        <= one_nxt;
      pend_r       <= pend_nxt;
    end
  end

  assign status.idle       = (state_r == ST_IDLE);
  assign status.done       = (state_r == ST_DONE);
  assign view.zero_count   = zero_r;
  assign view.one_count    = one_r;
  assign view.zero_pending = pend_r[0];
  assign view.one_pending  = pend_r[1];

  // tick count is spent once the sequencer leaves the tick loop
  a_ticks_spent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> (ticks_left_r == 8'd0))
    else $error("ticks left outside the tick loop");

  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T1) |-> ($past(state_r) == ST_T0))
    else $error("timer one phase without timer zero phase");

  // pending flags only drop on a clear request
  a_pend_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && req.operation == OP_CLEAR) |=> ((pend_r & $past(pend_r)) == $past(pend_r)))
    else $error("pending flag dropped without clear");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> ($stable(zero_r) && $stable(one_r)))
    else $error("timer changed after sequence finished");

endmodule

[rtl/dual_timer_tick_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_timer_tick_unit_core
// Two byte-split timers with run, mode and overflow pending control.
// ----------------------------------------------------------------------------
// One request at a time. An advance request of N ticks passes through the
// timer zero and timer one phases once per tick before out_rsp.valid rises,
// because a single incrementer unit is shared by both timers and serves one
// timer per cycle; the result is then loaded into the output register. A
// write, clear or zero-tick request goes straight to the done state. The
// input is not ready while a request is in the sequencer. A new request is
// accepted once the previous result has been loaded into the output
// register, so the next request can enter while that result still waits for
// out_rsp.ready.
module dual_timer_tick_unit_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtt_pkg::CFG_DATA_W-1:0]      cfg_data,
  dtt_in_if.sink                              in_req,
  dtt_out_if.source                           out_rsp
);
  import dtt_pkg::*;

  logic [7:0]   control_r;
  logic [7:0]   mode_r;
  logic         ien0_r;
  logic         ien1_r;
  logic         out_valid_r, out_valid_nxt;
  tmr_view_t    out_view_r;

  tmr_cfg_t     cfg;
  tmr_req_t     req;
  seq_status_t  status;
  tmr_view_t    view;
  logic         start;
  logic         take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= 8'd0;
      mode_r    <= 8'd0;
      ien0_r    <= 1'b0;
      ien1_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTROL: control_r <= cfg_data;
        REG_MODE:    mode_r    <= cfg_data;
        REG_IEN0:    ien0_r    <= cfg_data[0];
        REG_IEN1:    ien1_r    <= cfg_data[0];
        default: begin
          control_r <= control_r;
        end
      endcase
    end
  end

  assign cfg.run0  = control_r[RUN0_BIT];
  assign cfg.run1  = control_r[RUN1_BIT];
  assign cfg.mode0 = mode_r[MODE0_LSB +: 3];
  assign cfg.mode1 = mode_r[MODE1_LSB +: 3];
  assign cfg.ien0  = ien0_r;
  assign cfg.ien1  = ien1_r;

  assign req.operation   = in_req.operation;
  assign req.ticks       = in_req.ticks;
  assign req.byte_select = in_req.byte_select;
  assign req.byte_value  = in_req.byte_value;

  assign in_req.ready = status.idle;
  assign start        = in_req.valid && status.idle;

  // result moves to the output register when it is empty or draining
  assign take = status.done && (!out_valid_r || out_rsp.ready);

  dtt_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .start  (start),
    .req    (req),
    .take   (take),
    .status (status),
    .view   (view)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;
    if (take)          out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_view_r <= view;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.zero_low     = out_view_r.zero_count[7:0];
  assign out_rsp.zero_high    = out_view_r.zero_count[15:8];
  assign out_rsp.one_low      = out_view_r.one_count[7:0];
  assign out_rsp.one_high     = out_view_r.one_count[15:8];
  assign out_rsp.zero_pending = out_view_r.zero_pending;
  assign out_rsp.one_pending  = out_view_r.one_pending;

endmodule

[test/dtt_timer_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_timer_check
// Watches the request, result and configuration ports of the dual timer tick
// unit. It keeps its own copy of both timers, the pending flags and the
// registers, works out the view expected after every accepted request and
// compares each accepted result with the oldest expected view.
// ----------------------------------------------------------------------------
module dtt_timer_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtt_pkg::CFG_DATA_W-1:0] cfg_data,
  dtt_in_if                              req,
  dtt_out_if                             rsp,
  output int unsigned                    mismatch_count,
  output int unsigned                    views_owed
);
  import dtt_pkg::*;

  typedef struct packed {
    logic        wrapped;
    logic [15:0] count;
  } tick_t;

  logic [7:0]  run_bits;
  logic [7:0]  mode_bits;
  logic        zero_ien;
  logic        one_ien;
  logic [15:0] zero_count;
  logic [15:0] one_count;
  logic [1:0]  pending;
  tmr_req_t    seen_req;
  tmr_view_t   want;
  tmr_view_t   expected_views[$];
  int unsigned mismatches;
  logic        bad;

  function automatic tick_t tick_once(logic [15:0] count, logic [2:0] mode);
    logic [7:0] lo;
    logic [7:0] hi;
    tick_t      t;
    lo = count[7:0];
    hi = count[15:8];
    t.wrapped = 1'b0;
    case (mode)
      MODE_WIDE: begin
        lo = lo + 8'd1;
        if (lo == 8'd0) begin
          hi = hi + 8'd1;
          if (hi == 8'd0) t.wrapped = 1'b1;
        end
      end
      MODE_RELOAD: begin
        lo = lo + 8'd1;
        if (lo == 8'd0) begin
          lo = hi;
          t.wrapped = 1'b1;
        end
      end
      MODE_SPLIT: begin
        lo = lo + 8'd1;
        hi = hi + 8'd1;
        if (lo == 8'd0 || hi == 8'd0) t.wrapped = 1'b1;
      end
      default: ;
    endcase
    t.count = {hi, lo};
    return t;
  endfunction

  function automatic void apply_request(tmr_req_t r);
    tick_t t;
    int    n;
    case (r.operation)
      OP_ADVANCE: begin
        for (n = 0; n < int'(r.ticks); n++) begin
          if (run_bits[RUN0_BIT]) begin
            t = tick_once(zero_count, mode_bits[MODE0_LSB +: 3]);
            zero_count = t.count;
            if (t.wrapped && zero_ien) pending[0] = 1'b1;
          end
          if (run_bits[RUN1_BIT]) begin
            t = tick_once(one_count, mode_bits[MODE1_LSB +: 3]);
            one_count = t.count;
            if (t.wrapped && one_ien) pending[1] = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        if (r.byte_select[SEL_TIMER_BIT]) begin
          if (r.byte_select[SEL_HIGH_BIT]) one_count[15:8] = r.byte_value;
          else one_count[7:0] = r.byte_value;
        end else begin
          if (r.byte_select[SEL_HIGH_BIT]) zero_count[15:8] = r.byte_value;
          else zero_count[7:0] = r.byte_value;
        end
      end
      OP_CLEAR: pending = 2'b00;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      run_bits = '0;
      mode_bits = '0;
      zero_ien = 1'b0;
      one_ien = 1'b0;
      zero_count = '0;
      one_count = '0;
      pending = '0;
      expected_views.delete();
      mismatches = 0;
    end else begin
      // retire the result first, the request taken at this edge queues behind it
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request waiting: t0 %h%h t1 %h%h pend %b%b",
                     $realtime, rsp.zero_high, rsp.zero_low, rsp.one_high, rsp.one_low,
                     rsp.one_pending, rsp.zero_pending);
        end else begin
          want = expected_views.pop_front();
          bad = (rsp.zero_low != want.zero_count[7:0]) ||
                (rsp.zero_high != want.zero_count[15:8]) ||
                (rsp.one_low != want.one_count[7:0]) ||
                (rsp.one_high != want.one_count[15:8]) ||
                (rsp.zero_pending != want.zero_pending) ||
                (rsp.one_pending != want.one_pending);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: t0 %h%h t1 %h%h pend %b%b, expected t0 %h t1 %h pend %b%b",
                       $realtime, rsp.zero_high, rsp.zero_low, rsp.one_high, rsp.one_low,
                       rsp.one_pending, rsp.zero_pending, want.zero_count, want.one_count,
                       want.one_pending, want.zero_pending);
          end
        end
      end
      if (req.valid && req.ready) begin
        seen_req.operation = req.operation;
        seen_req.ticks = req.ticks;
        seen_req.byte_select = req.byte_select;
        seen_req.byte_value = req.byte_value;
        apply_request(seen_req);
        want.zero_count = zero_count;
        want.one_count = one_count;
        want.zero_pending = pending[0];
        want.one_pending = pending[1];
        expected_views.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CONTROL: run_bits = cfg_data;
          REG_MODE:    mode_bits = cfg_data;
          REG_IEN0:    zero_ien = cfg_data[0];
          REG_IEN1:    one_ien = cfg_data[0];
          default: ;
        endcase
      end
    end
    views_owed <= expected_views.size();
    mismatch_count <= mismatches;
  end

endmodule

[test/dual_timer_tick_unit_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_timer_tick_unit_core_test
// Drives the dual timer tick unit with directed requests on counter wrap,
// reload, split and idle modes, then with randomized phases of settings and
// requests under random gaps and stalls on both channels. The timer check
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dual_timer_tick_unit_core_test;
  import dtt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] SEL_ZERO_LOW  = 2'd0;
  localparam logic [1:0] SEL_ZERO_HIGH = 2'd1;
  localparam logic [1:0] SEL_ONE_LOW   = 2'd2;
  localparam logic [1:0] SEL_ONE_HIGH  = 2'd3;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_IDLE_TOP = 3'd7;

  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 600;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatch_count;
  int unsigned           views_owed;
  bit                    sender_eager;
  bit                    receiver_eager;
  int unsigned           hold_off_cycles;

  dtt_in_if  req_if ();
  dtt_out_if rsp_if ();

  dual_timer_tick_unit_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (req_if),
    .out_rsp   (rsp_if)
  );

  dtt_timer_check timer_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req            (req_if),
    .rsp            (rsp_if),
    .mismatch_count (mismatch_count),
    .views_owed     (views_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] run_byte(logic run_zero, logic run_one);
    logic [7:0] b;
    b = 8'h00;
    b[RUN0_BIT] = run_zero;
    b[RUN1_BIT] = run_one;
    return b;
  endfunction

  function automatic logic [7:0] mode_byte(logic [2:0] zero_mode, logic [2:0] one_mode);
    logic [7:0] b;
    b = 8'h00;
    b[MODE0_LSB +: 3] = zero_mode;
    b[MODE1_LSB +: 3] = one_mode;
    return b;
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_request(input logic [1:0] op, input logic [7:0] ticks,
                              input logic [1:0] sel, input logic [7:0] val);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.ticks <= ticks;
    req_if.byte_select <= sel;
    req_if.byte_value <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (views_owed != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] ctrl, input logic [7:0] mode,
                                input logic ien0, input logic ien1);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_CONTROL;
    cfg_data <= ctrl;
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data <= mode;
    @(posedge clk);
    // upper data bits are don't care for the enable registers
    cfg_index <= REG_IEN0;
    cfg_data <= {7'($urandom), ien0};
    @(posedge clk);
    cfg_index <= REG_IEN1;
    cfg_data <= {7'($urandom), ien1};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [7:0]  ticks;
    logic [7:0]  val;
    pick = $urandom_range(0, 99);
    ticks = 8'($urandom);
    if ($urandom_range(0, 9) < 7) ticks = 8'($urandom_range(0, 20));
    val = 8'($urandom);
    // values near the top make wraps likely
    if ($urandom_range(0, 1) == 1) val = 8'(255 - $urandom_range(0, 15));
    if (pick < 55)
      send_request(OP_ADVANCE, ticks, 2'($urandom), 8'($urandom));
    else if (pick < 85)
      send_request(OP_WRITE, 8'($urandom), 2'($urandom), val);
    else if (pick < 95)
      send_request(OP_CLEAR, 8'($urandom), 2'($urandom), 8'($urandom));
    else
      send_request(OP_UNUSED, 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(input int unsigned items);
    logic [7:0] ctrl;
    logic [7:0] mode;
    ctrl = 8'($urandom);
    ctrl[RUN0_BIT] = ($urandom_range(0, 3) != 0);
    ctrl[RUN1_BIT] = ($urandom_range(0, 3) != 0);
    mode = 8'($urandom);
    if ($urandom_range(0, 4) != 0) mode[MODE0_LSB +: 3] = 3'($urandom_range(1, 3));
    if ($urandom_range(0, 4) != 0) mode[MODE1_LSB +: 3] = 3'($urandom_range(1, 3));
    write_settings(ctrl, mode, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
    sender_eager = ($urandom_range(0, 3) == 0);
    receiver_eager = ($urandom_range(0, 3) == 0);
    repeat (items) begin
      random_request();
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end
  endtask

  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stall = receiver_eager ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CONTROL;
    cfg_data <= '0;
    req_if.valid <= 1'b0;
    req_if.operation <= OP_ADVANCE;
    req_if.ticks <= '0;
    req_if.byte_select <= SEL_ZERO_LOW;
    req_if.byte_value <= '0;
    sender_eager = 1'b0;
    receiver_eager = 1'b0;
    hold_off_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing runs, byte writes at the extremes
    send_request(OP_ADVANCE, 8'hFF, 2'($urandom), 8'($urandom));
    send_request(OP_UNUSED, 8'($urandom), 2'($urandom), 8'($urandom));
    send_request(OP_WRITE, 8'($urandom), SEL_ZERO_LOW, 8'hFF);
    send_request(OP_WRITE, 8'($urandom), SEL_ZERO_HIGH, 8'hFF);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_LOW, 8'hFE);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_HIGH, 8'hFF);

    // 16-bit wrap on both timers, zero ticks, clear
    write_settings(run_byte(1'b1, 1'b1), mode_byte(MODE_WIDE, MODE_WIDE), 1'b1, 1'b1);
    send_request(OP_ADVANCE, 8'd1, 2'($urandom), 8'($urandom));
    send_request(OP_ADVANCE, 8'd0, 2'($urandom), 8'($urandom));
    send_request(OP_ADVANCE, 8'd1, 2'($urandom), 8'($urandom));
    send_request(OP_CLEAR, 8'($urandom), 2'($urandom), 8'($urandom));
    send_request(OP_ADVANCE, 8'hFF, 2'($urandom), 8'($urandom));

    // reload on timer zero, split on timer one with its enable off
    write_settings(8'hFF, mode_byte(MODE_RELOAD, MODE_SPLIT), 1'b1, 1'b0);
    send_request(OP_WRITE, 8'($urandom), SEL_ZERO_HIGH, 8'hF0);
    send_request(OP_WRITE, 8'($urandom), SEL_ZERO_LOW, 8'hFE);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_LOW, 8'hFF);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_HIGH, 8'h7F);
    send_request(OP_ADVANCE, 8'd3, 2'($urandom), 8'($urandom));
    send_request(OP_CLEAR, 8'($urandom), 2'($urandom), 8'($urandom));
    send_request(OP_ADVANCE, 8'hFF, 2'($urandom), 8'($urandom));

    // only timer one runs, in reload mode; spare mode bits set
    write_settings(run_byte(1'b0, 1'b1), mode_byte(MODE_SPLIT, MODE_RELOAD) | 8'h88,
                   1'b0, 1'b1);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_HIGH, 8'hFD);
    send_request(OP_WRITE, 8'($urandom), SEL_ONE_LOW, 8'hFF);
    send_request(OP_ADVANCE, 8'hFF, 2'($urandom), 8'($urandom));
    send_request(OP_UNUSED, 8'($urandom), 2'($urandom), 8'($urandom));

    // idle modes hold both timers
    write_settings(8'hFF, mode_byte(MODE_IDLE, MODE_IDLE_TOP), 1'b1, 1'b1);
    send_request(OP_ADVANCE, 8'd100, 2'($urandom), 8'($urandom));

    // extreme settings
    write_settings(8'hFF, 8'hFF, 1'b1, 1'b1);
    repeat (20) random_request();
    write_settings(8'h00, 8'h00, 1'b0, 1'b0);
    repeat (10) random_request();

    // long receiver hold-off while requests keep coming, then a full pause
    write_settings(run_byte(1'b1, 1'b1), mode_byte(MODE_WIDE, MODE_SPLIT), 1'b1, 1'b1);
    sender_eager = 1'b1;
    receiver_eager = 1'b0;
    hold_off_cycles = LONG_HOLD;
    repeat (30) random_request();
    wait_for_drain();

    for (int p = 0; p < 20; p++) random_phase(58);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
